@@ hw/rtl/ifmt_pkg.sv @@
// ----------------------------------------------------------------------------
// ifmt_pkg
// Shared types and constants for the integer field formatter: conversion
// kinds, character codes, controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package ifmt_pkg;

    // fixed field widths of the ports
    localparam int VALUE_IN_BITS = 64;
    localparam int FUNC_BITS     = 3;
    localparam int FW_BITS       = 7;
    localparam int CH_BITS       = 8;

    // digit register: enough decimal digits for a 64-bit magnitude
    localparam int NDIG    = 20;
    localparam int DIG_W   = NDIG * 4;
    localparam int ND_BITS = 5;

    // ascii codes
    localparam logic [CH_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_BITS-1:0] CH_X     = 8'h78;
    localparam logic [CH_BITS-1:0] CH_UA    = 8'h41;
    localparam logic [CH_BITS-1:0] CH_LA    = 8'h61;

    // conversion kinds; codes above pointer act as unsigned decimal
    typedef enum logic [FUNC_BITS-1:0] {
        K_UDEC = 3'd0,
        K_SDEC = 3'd1,
        K_LHEX = 3'd2,
        K_UHEX = 3'd3,
        K_PTR  = 3'd4
    } t_kind;

    // which character source feeds the output register
    typedef enum logic [1:0] {
        SEL_SPACE = 2'd0,
        SEL_HEAD  = 2'd1,
        SEL_ZERO  = 2'd2,
        SEL_DIGIT = 2'd3
    } t_chsel;

    // controller to datapath
    typedef struct packed {
        logic   load;
        logic   conv;
        logic   trim;
        logic   plan;
        logic   emit;
        t_chsel sel;
        logic   last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic conv_done;
        logic trim_done;
        logic pad_empty;
        logic pad_one;
        logic head_zero;
        logic dig_one;
        logic mode_pre;
        logic mode_zero;
        logic mode_post;
        logic out_free;
    } t_sts;

    // one digit value to its ascii character
    function automatic logic [CH_BITS-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CH_BITS-1:0] base;
        base = upper ? CH_UA : CH_LA;
        if (d < 4'd10) begin
            return CH_ZERO + {4'd0, d};
        end
        return base + {4'd0, d} - 8'd10;
    endfunction

endpackage

@@ hw/rtl/ifmt_dpath.sv @@
// ----------------------------------------------------------------------------
// ifmt_dpath
// Datapath: operand capture and negation, shift-add-3 binary to decimal
// conversion one bit per cycle, leading zero trim, pad count and the
// registered character output.
// ----------------------------------------------------------------------------
module ifmt_dpath #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_WIDTH  = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ifmt_pkg::t_cmd                        i_cmd,
    output ifmt_pkg::t_sts                        o_sts,
    input  logic [ifmt_pkg::VALUE_IN_BITS-1:0]    i_value,
    input  logic [ifmt_pkg::FUNC_BITS-1:0]        i_func,
    input  logic [ifmt_pkg::FW_BITS-1:0]          i_field_width,
    input  logic                                  i_zero_pad,
    input  logic                                  i_left_justify,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [ifmt_pkg::CH_BITS-1:0]          o_ch,
    output logic                                  o_last
);
    import ifmt_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] r_bin;
    logic [DIG_W-1:0]      r_dig;
    logic [CNT_W-1:0]      r_cnt;
    logic [ND_BITS-1:0]    r_nd;
    logic [1:0]            r_head;
    logic                  r_ptr;
    logic                  r_upper;
    logic                  r_zpad;
    logic                  r_ljust;
    logic [FW_BITS-1:0]    r_width;
    logic [FW_BITS-1:0]    r_pad;
    logic                  r_out_valid;
    logic [CH_BITS-1:0]    r_out_ch;
    logic                  r_out_last;

    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] mag;
    logic                  neg;
    logic                  hex;
    logic [FW_BITS-1:0]    width_c;
    logic [DIG_W-1:0]      dig_adj;
    logic [FW_BITS-1:0]    content;
    logic [3:0]            top_nib;
    logic [CH_BITS-1:0]    ch;

    // operand decode at capture
    always_comb begin
        v   = i_value[VALUE_BITS-1:0];
        hex = (i_func == K_LHEX) || (i_func == K_UHEX) || (i_func == K_PTR);
        neg = (i_func == K_SDEC) && v[VALUE_BITS-1];
        mag = neg ? (~v + VALUE_BITS'(1)) : v;
        width_c = (i_field_width > FW_BITS'(MAX_WIDTH)) ? FW_BITS'(MAX_WIDTH) : i_field_width;
    end

    // add 3 to every bcd digit of 5 or more
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            dig_adj[4*i +: 4] = (r_dig[4*i +: 4] >= 4'd5) ? r_dig[4*i +: 4] + 4'd3
                                                            : r_dig[4*i +: 4];
        end
    end

    assign top_nib = r_dig[DIG_W-1 -: 4];
    assign content = FW_BITS'(r_head) + FW_BITS'(r_nd);

    // conversion, trim, plan and emit bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin   <= mag;
            r_dig   <= hex ? DIG_W'(mag) : '0;
            r_cnt   <= hex ? '0 : CNT_W'(VALUE_BITS);
            r_nd    <= ND_BITS'(NDIG);
            r_head  <= (i_func == K_PTR) ? 2'd2 : (neg ? 2'd1 : 2'd0);
            r_ptr   <= (i_func == K_PTR);
            r_upper <= (i_func == K_UHEX);
            r_zpad  <= i_zero_pad;
            r_ljust <= i_left_justify;
            r_width <= width_c;
        end else if (i_cmd.conv) begin
            r_dig <= {dig_adj[DIG_W-2:0], r_bin[VALUE_BITS-1]};
            r_bin <= r_bin << 1;
            r_cnt <= r_cnt - CNT_W'(1);
        end else if (i_cmd.trim) begin
            r_dig <= r_dig << 4;
            r_nd  <= r_nd - ND_BITS'(1);
        end else if (i_cmd.plan) begin
            r_pad <= (r_width > content) ? (r_width - content) : '0;
        end else if (i_cmd.emit) begin
            case (i_cmd.sel)
                SEL_HEAD: r_head <= r_head - 2'd1;
                SEL_DIGIT: begin
                    r_dig <= r_dig << 4;
                    r_nd  <= r_nd - ND_BITS'(1);
                end
                default: r_pad <= r_pad - FW_BITS'(1);
            endcase
        end
    end

    // character source select
    always_comb begin
        case (i_cmd.sel)
            SEL_SPACE: ch = CH_SPACE;
            SEL_HEAD:  ch = r_ptr ? ((r_head == 2'd2) ? CH_ZERO : CH_X) : CH_MINUS;
            SEL_ZERO:  ch = CH_ZERO;
            default:   ch = digit_char(top_nib, r_upper);
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_ch   <= ch;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ch        = r_out_ch;
    assign o_last      = r_out_last;

    // status to controller
    always_comb begin
        o_sts.conv_done = (r_cnt == '0);
        o_sts.trim_done = (top_nib != 4'd0) || (r_nd == ND_BITS'(1));
        o_sts.pad_empty = (r_pad == '0);
        o_sts.pad_one   = (r_pad == FW_BITS'(1));
        o_sts.head_zero = (r_head == 2'd0);
        o_sts.dig_one   = (r_nd == ND_BITS'(1));
        o_sts.mode_pre  = !r_ljust && !r_zpad;
        o_sts.mode_zero = !r_ljust && r_zpad;
        o_sts.mode_post = r_ljust;
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

endmodule

@@ hw/rtl/ifmt_ctrl.sv @@
// ----------------------------------------------------------------------------
// ifmt_ctrl
// Controller: sequences capture, conversion, trim, pad planning and the
// character phases (leading spaces, sign or prefix, zeros, digits,
// trailing spaces).
// ----------------------------------------------------------------------------
module ifmt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ifmt_pkg::t_sts i_sts,
    output ifmt_pkg::t_cmd o_cmd
);
    import ifmt_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b0_0000_0001,
        S_CONV = 9'b0_0000_0010,
        S_TRIM = 9'b0_0000_0100,
        S_PLAN = 9'b0_0000_1000,
        S_PRE  = 9'b0_0001_0000,
        S_HEAD = 9'b0_0010_0000,
        S_ZERO = 9'b0_0100_0000,
        S_DIG  = 9'b0_1000_0000,
        S_POST = 9'b1_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.sel  = SEL_SPACE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                if (i_sts.conv_done) begin
                    n_state = S_TRIM;
                end else begin
                    o_cmd.conv = 1'b1;
                end
            end
            S_TRIM: begin
                if (i_sts.trim_done) begin
                    n_state = S_PLAN;
                end else begin
                    o_cmd.trim = 1'b1;
                end
            end
            S_PLAN: begin
                o_cmd.plan = 1'b1;
                n_state    = S_PRE;
            end
            S_PRE: begin
                if (!i_sts.mode_pre || i_sts.pad_empty) begin
                    n_state = S_HEAD;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_SPACE;
                end
            end
            S_HEAD: begin
                if (i_sts.head_zero) begin
                    n_state = S_ZERO;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_HEAD;
                end
            end
            S_ZERO: begin
                if (!i_sts.mode_zero || i_sts.pad_empty) begin
                    n_state = S_DIG;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_ZERO;
                end
            end
            S_DIG: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_DIGIT;
                    o_cmd.last = i_sts.dig_one && (!i_sts.mode_post || i_sts.pad_empty);
                    if (i_sts.dig_one) begin
                        n_state = (i_sts.mode_post && !i_sts.pad_empty) ? S_POST : S_IDLE;
                    end
                end
            end
            S_POST: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_SPACE;
                    o_cmd.last = i_sts.pad_one;
                    if (i_sts.pad_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hw/rtl/integer_field_formatter.sv @@
// sequence: a capture step, then shift-add-3 conversion for decimal kinds (none for hex), a
// trim step per leading zero digit, a plan step, then the character phases with one character
// issued per step while the output is free; each character leaves the cycle after it is issued.
// flow: one item at a time; a new field is taken only once the controller is back in idle,
// and output stalls hold the character phases.
// reset: i_rst_n synchronous active low clears the controller and output valid.
// ----------------------------------------------------------------------------
// integer_field_formatter
// Formats one integer as a printf-style decimal or hex field and streams
// it out as ascii characters, last character marked.
// ----------------------------------------------------------------------------
module integer_field_formatter #(
    parameter int VALUE_BITS = 64,
    parameter int MAX_WIDTH  = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [ifmt_pkg::VALUE_IN_BITS-1:0]    i_value,
    input  logic [ifmt_pkg::FUNC_BITS-1:0]        i_func,
    input  logic [ifmt_pkg::FW_BITS-1:0]          i_field_width,
    input  logic                                  i_zero_pad,
    input  logic                                  i_left_justify,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [ifmt_pkg::CH_BITS-1:0]          o_ch,
    output logic                                  o_last
);
    import ifmt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    ifmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // conversion and output datapath
    ifmt_dpath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_value        (i_value),
        .i_func         (i_func),
        .i_field_width  (i_field_width),
        .i_zero_pad     (i_zero_pad),
        .i_left_justify (i_left_justify),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_ch           (o_ch),
        .o_last         (o_last)
    );

endmodule

@@ sim/integer_field_formatter_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_field_formatter_checker
// Watches both channels of the formatter. Every accepted field is expanded
// into the character stream it must produce, and every character transfer is
// compared against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module integer_field_formatter_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_value,
    input  logic [2:0]  i_func,
    input  logic [6:0]  i_field_width,
    input  logic        i_zero_pad,
    input  logic        i_left_justify,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_chars_checked
);
    import ifmt_pkg::*;

    localparam int FIELD_MAX = 64;

    typedef struct packed {
        logic [CH_BITS-1:0] ch;
        logic               last;
    } t_field_char;

    // characters still owed by the block, oldest first
    t_field_char owed_chars_q[$];

    // expand one field into its characters and queue them
    function automatic void format_field(input logic [63:0] value, input logic [2:0] func,
                                         input logic [6:0] fw, input logic zpad,
                                         input logic ljust);
        t_kind              kind;
        logic [63:0]        mag;
        logic [63:0]        radix;
        logic [3:0]         d;
        string              digit_set;
        logic [CH_BITS-1:0] prefix [$];
        logic [CH_BITS-1:0] digits [$];
        logic [CH_BITS-1:0] line [$];
        int                 width;
        int                 pad;
        t_field_char        item;
        kind      = (func > K_PTR) ? K_UDEC : t_kind'(func);
        width     = (fw > FIELD_MAX) ? FIELD_MAX : int'(fw);
        mag       = value;
        radix     = 64'd10;
        digit_set = "0123456789abcdef";
        // sign or prefix, and the digit alphabet
        case (kind)
            K_SDEC: begin
                if (mag[63]) begin
                    prefix.push_back(CH_MINUS);
                    mag = -mag;
                end
            end
            K_LHEX: radix = 64'd16;
            K_UHEX: begin
                radix     = 64'd16;
                digit_set = "0123456789ABCDEF";
            end
            K_PTR: begin
                radix = 64'd16;
                prefix.push_back(CH_ZERO);
                prefix.push_back(CH_X);
            end
            default: ;
        endcase
        // digits, most significant at the front
        do begin
            d = 4'(mag % radix);
            digits.push_front(digit_set[d]);
            mag = mag / radix;
        end while (mag != 0);
        pad = width - prefix.size() - digits.size();
        if (pad < 0) pad = 0;
        if (!ljust && !zpad) repeat (pad) line.push_back(CH_SPACE);
        foreach (prefix[i]) line.push_back(prefix[i]);
        if (!ljust && zpad) repeat (pad) line.push_back(CH_ZERO);
        foreach (digits[i]) line.push_back(digits[i]);
        if (ljust) repeat (pad) line.push_back(CH_SPACE);
        foreach (line[i]) begin
            item.ch   = line[i];
            item.last = (i == line.size() - 1);
            owed_chars_q.push_back(item);
        end
    endfunction

    // count a failure, print only the first few
    function automatic void flag_failure(input string what);
        o_fail_count++;
        if (o_fail_count <= 10) $display("[%0t] checker: %s", $realtime, what);
    endfunction

    always @(posedge i_clk) begin : watch
        t_field_char want;
        if (i_rst_n) begin
            // character transfer: compare against the oldest owed character
            if (i_out_valid && i_out_ready) begin
                o_chars_checked++;
                if (owed_chars_q.size() == 0) begin
                    flag_failure($sformatf("unexpected char 0x%02h last %0b, nothing owed",
                                           i_ch, i_last));
                end else begin
                    want = owed_chars_q.pop_front();
                    if (want.ch !== i_ch || want.last !== i_last)
                        flag_failure($sformatf("char exp 0x%02h last %0b, got 0x%02h last %0b",
                                               want.ch, want.last, i_ch, i_last));
                end
            end
            // field transfer: queue what it must produce
            if (i_in_valid && i_in_ready)
                format_field(i_value, i_func, i_field_width, i_zero_pad, i_left_justify);
            o_pending = owed_chars_q.size();
        end
    end

endmodule

@@ sim/integer_field_formatter_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_field_formatter_tb
// Drives formatted-integer requests into the formatter: a directed set of
// corner fields, then random fields of every kind, width and flag mix, with
// random idle cycles on both channels. The checker grades the characters.
// ----------------------------------------------------------------------------
module integer_field_formatter_tb;
    import ifmt_pkg::*;

    // func codes past pointer hex, treated as unsigned decimal
    localparam logic [2:0] FUNC_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] FUNC_UNKNOWN_HI = 3'd7;
    localparam int         RANDOM_FIELDS   = 450;
    localparam int         DRAIN_CYCLES    = 200;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [63:0] i_value        = '0;
    logic [2:0]  i_func         = '0;
    logic [6:0]  i_field_width  = '0;
    logic        i_zero_pad     = 1'b0;
    logic        i_left_justify = 1'b0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_ch;
    logic        o_last;

    int   fail_count;
    int   chars_owed;
    int   chars_checked;
    int   fields_sent;
    int   unknown_kinds;
    int   clamped_widths;
    logic calm = 1'b0;

    integer_field_formatter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_value        (i_value),
        .i_func         (i_func),
        .i_field_width  (i_field_width),
        .i_zero_pad     (i_zero_pad),
        .i_left_justify (i_left_justify),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_ch           (o_ch),
        .o_last         (o_last)
    );

    integer_field_formatter_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_value         (i_value),
        .i_func          (i_func),
        .i_field_width   (i_field_width),
        .i_zero_pad      (i_zero_pad),
        .i_left_justify  (i_left_justify),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_ch            (o_ch),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_pending       (chars_owed),
        .o_chars_checked (chars_checked)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // character sink stalls now and then, never during the calm stretch
    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 8);
    end

    // present one field and hold it until the transfer happens
    task automatic send_field(input logic [63:0] value, input logic [2:0] func,
                              input logic [6:0] fw, input logic zpad, input logic ljust);
        while (!calm && $urandom_range(0, 99) < 8) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_value        <= value;
        i_func         <= func;
        i_field_width  <= fw;
        i_zero_pad     <= zpad;
        i_left_justify <= ljust;
        do @(posedge i_clk); while (!o_in_ready);
        fields_sent++;
        if (func > K_PTR) unknown_kinds++;
        if (fw > 7'd64) clamped_widths++;
        @(negedge i_clk);
    endtask

    // hold off the sender until every owed character has come out
    task automatic drain_output();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (chars_owed != 0) @(negedge i_clk);
    endtask

    // operand values biased toward digit-count and sign boundaries
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        logic [63:0] p;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 6))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 99));
            2: v = v >> $urandom_range(0, 63);
            3: begin
                p = 64'd1;
                repeat ($urandom_range(0, 19)) p = p * 64'd10;
                v = p + 64'($urandom_range(0, 2)) - 64'd1;
            end
            4: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
            5: v = -(v >> $urandom_range(1, 63));
            default: begin
                case ($urandom_range(0, 3))
                    0: v = '0;
                    1: v = '1;
                    2: v = 64'h8000_0000_0000_0000;
                    default: v = 64'h7FFF_FFFF_FFFF_FFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    // stimulus and verdict
    initial begin
        logic [2:0] func;
        logic [6:0] fw;
        int         r;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // corner fields
        send_field(64'd0,                    K_UDEC, 7'd0,   1'b0, 1'b0);
        send_field('1,                       K_UDEC, 7'd0,   1'b0, 1'b0);
        send_field(64'h8000_0000_0000_0000,  K_SDEC, 7'd0,   1'b0, 1'b0);
        send_field(64'h8000_0000_0000_0000,  K_SDEC, 7'd30,  1'b1, 1'b0);
        send_field('1,                       K_SDEC, 7'd6,   1'b1, 1'b0);
        send_field(64'h7FFF_FFFF_FFFF_FFFF,  K_SDEC, 7'd25,  1'b0, 1'b0);
        send_field(64'd0,                    K_SDEC, 7'd1,   1'b0, 1'b0);
        send_field(-64'd42,                  K_SDEC, 7'd10,  1'b0, 1'b1);
        send_field(64'hDEAD_BEEF_0123_4567,  K_LHEX, 7'd20,  1'b1, 1'b0);
        send_field('1,                       K_UHEX, 7'd0,   1'b0, 1'b0);
        send_field(64'h0000_00AB_CDEF_0000,  K_UHEX, 7'd16,  1'b0, 1'b0);
        send_field(64'd0,                    K_PTR,  7'd0,   1'b0, 1'b0);
        send_field(64'd0,                    K_PTR,  7'd8,   1'b1, 1'b0);
        send_field(64'h0000_7FFE_1234_ABCD,  K_PTR,  7'd24,  1'b0, 1'b1);
        send_field(64'd123456789,            FUNC_UNKNOWN_LO,        7'd12, 1'b1, 1'b0);
        send_field(-64'd1,                   FUNC_UNKNOWN_LO + 3'd1, 7'd0,  1'b0, 1'b0);
        send_field(64'd77,                   FUNC_UNKNOWN_HI,        7'd5,  1'b0, 1'b1);
        send_field(64'd5,                    K_UDEC, 7'd127, 1'b0, 1'b0);
        send_field(-64'd5,                   K_SDEC, 7'd65,  1'b1, 1'b0);
        send_field(64'hF,                    K_LHEX, 7'd64,  1'b0, 1'b1);
        send_field(64'd987654321,            K_UDEC, 7'd3,   1'b1, 1'b0);
        send_field(64'd31,                   K_PTR,  7'd100, 1'b1, 1'b1);
        send_field(64'd9,                    K_UDEC, 7'd1,   1'b1, 1'b1);
        drain_output();

        // random fields, with one calm stretch and one full drain midway
        for (int n = 0; n < RANDOM_FIELDS; n++) begin
            calm = (n >= 150 && n < 260);
            if (n == 300) drain_output();
            if ($urandom_range(0, 99) < 6)
                func = 3'($urandom_range(FUNC_UNKNOWN_LO, FUNC_UNKNOWN_HI));
            else
                func = 3'($urandom_range(K_UDEC, K_PTR));
            r = $urandom_range(0, 99);
            if (r < 70)
                fw = 7'($urandom_range(0, 24));
            else if (r < 92)
                fw = 7'($urandom_range(25, 64));
            else
                fw = 7'($urandom_range(65, 127));
            send_field(pick_value(), func, fw, 1'($urandom), 1'($urandom));
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        // let every owed character out, then watch for strays
        while (chars_owed != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d fields (%0d unknown kind codes, %0d clamped widths)",
                 fields_sent, unknown_kinds, clamped_widths);
        $display("%0d characters checked, %0d failures, %0d still owed",
                 chars_checked, fail_count, chars_owed);
        if (fail_count == 0 && chars_owed == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #8_000_000;
        $display("timeout with %0d characters owed", chars_owed);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ integer_field_formatter.f @@
hw/rtl/ifmt_pkg.sv
hw/rtl/ifmt_dpath.sv
hw/rtl/ifmt_ctrl.sv
hw/rtl/integer_field_formatter.sv
sim/integer_field_formatter_checker.sv
sim/integer_field_formatter_tb.sv
